// ===== rtl/icaf_pkg.sv =====
// Shared types, constants and the arcsine lookup for the IMU angle filter.
// No dependencies; imported by every module of the block.
package icaf_pkg;

    localparam int SAMPLE_W   = 11;
    localparam int ANGLE_W    = 16;
    localparam int TICK_W     = 32;
    localparam int DT_W       = 16;
    localparam int TRIM_W     = 8;
    localparam int WEIGHT_W   = 9;
    localparam int MUL_W      = 17;
    localparam int PROD_W     = 27;
    localparam int CFG_IDX_W  = 2;
    localparam int S_TDATA_W  = 104;
    localparam int M_TDATA_W  = 136;
    localparam int TAB_LEN    = 64;
    localparam int TAB_IDX_W  = 6;
    localparam int TAB_VAL_W  = 7;

    localparam logic [WEIGHT_W-1:0] WEIGHT_FULL  = WEIGHT_W'(256);
    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = WEIGHT_W'(1);
    localparam logic [ANGLE_W-1:0]  VERT_OFFSET  = ANGLE_W'(90 * 256);

    localparam logic [CFG_IDX_W-1:0] CFG_TRIM_ROLL  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_TRIM_PITCH = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_MIX_WEIGHT = CFG_IDX_W'(2);

    // multiplier operation issued by the controller
    typedef enum logic [2:0] {
        OP_NONE,
        OP_RATE_R,
        OP_RATE_P,
        OP_RATE_Y,
        OP_MIX_R_GYRO,
        OP_MIX_R_ACC,
        OP_MIX_P_GYRO,
        OP_MIX_P_ACC
    } op_t;

    typedef struct packed {
        logic load;
        op_t  op;
        logic commit;
    } cmd_t;

    localparam logic [TAB_VAL_W-1:0] ASIN_TAB [TAB_LEN] = '{
        7'd0,  7'd1,  7'd2,  7'd3,  7'd4,  7'd5,  7'd5,  7'd6,
        7'd7,  7'd8,  7'd9,  7'd10, 7'd11, 7'd12, 7'd13, 7'd14,
        7'd15, 7'd16, 7'd17, 7'd18, 7'd19, 7'd19, 7'd20, 7'd21,
        7'd22, 7'd23, 7'd24, 7'd25, 7'd26, 7'd27, 7'd28, 7'd29,
        7'd31, 7'd32, 7'd33, 7'd34, 7'd35, 7'd36, 7'd37, 7'd38,
        7'd39, 7'd41, 7'd42, 7'd43, 7'd44, 7'd46, 7'd47, 7'd48,
        7'd50, 7'd51, 7'd53, 7'd54, 7'd56, 7'd57, 7'd59, 7'd61,
        7'd63, 7'd65, 7'd67, 7'd69, 7'd72, 7'd76, 7'd80, 7'd90
    };

    // Accelerometer angle in degrees*256: table entry doubled, odd bit
    // appended, sign restored, offset added with 16-bit wrap.
    function automatic logic [ANGLE_W-1:0] tilt_from_accel(
        input logic [SAMPLE_W-1:0] a,
        input logic [ANGLE_W-1:0]  offset
    );
        logic [SAMPLE_W-1:0]  mag;
        logic [TAB_IDX_W-1:0] idx;
        logic [TAB_VAL_W:0]   c;
        logic [ANGLE_W-1:0]   mag_ang;
        mag = a[SAMPLE_W-1] ? (~a + SAMPLE_W'(1)) : a;
        // magnitudes of 128 and above saturate to the last entry
        if (mag[SAMPLE_W-1:TAB_IDX_W+1] != '0) begin
            idx = TAB_IDX_W'(TAB_LEN - 1);
        end else begin
            idx = mag[TAB_IDX_W:1];
        end
        c       = {ASIN_TAB[idx], mag[0]};
        mag_ang = {1'b0, c, 7'd0};
        if (a[SAMPLE_W-1]) begin
            mag_ang = ~mag_ang + ANGLE_W'(1);
        end
        return mag_ang + offset;
    endfunction

endpackage

// ===== rtl/icaf_ctrl.sv =====
// Sequencer for the IMU angle filter: schedules the shared multiplier,
// owns the input/output handshakes. Depends on icaf_pkg.
module icaf_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic                m_tready,
    output logic                m_tvalid,
    output icaf_pkg::cmd_t      cmd
);
    import icaf_pkg::*;

    typedef enum logic [9:0] {
        ST_IDLE    = 10'b00_0000_0001,
        ST_RATE_R  = 10'b00_0000_0010,
        ST_RATE_P  = 10'b00_0000_0100,
        ST_RATE_Y  = 10'b00_0000_1000,
        ST_MIX_RG  = 10'b00_0001_0000,
        ST_MIX_RA  = 10'b00_0010_0000,
        ST_MIX_PG  = 10'b00_0100_0000,
        ST_MIX_PA  = 10'b00_1000_0000,
        ST_DRAIN   = 10'b01_0000_0000,
        ST_FINISH  = 10'b10_0000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   out_free;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        state_next = state_reg;
        cmd.load   = 1'b0;
        cmd.op     = OP_NONE;
        cmd.commit = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_RATE_R;
                end
            end
            ST_RATE_R: begin
                cmd.op     = OP_RATE_R;
                state_next = ST_RATE_P;
            end
            ST_RATE_P: begin
                cmd.op     = OP_RATE_P;
                state_next = ST_RATE_Y;
            end
            ST_RATE_Y: begin
                cmd.op     = OP_RATE_Y;
                state_next = ST_MIX_RG;
            end
            ST_MIX_RG: begin
                cmd.op     = OP_MIX_R_GYRO;
                state_next = ST_MIX_RA;
            end
            ST_MIX_RA: begin
                cmd.op     = OP_MIX_R_ACC;
                state_next = ST_MIX_PG;
            end
            ST_MIX_PG: begin
                cmd.op     = OP_MIX_P_GYRO;
                state_next = ST_MIX_PA;
            end
            ST_MIX_PA: begin
                cmd.op     = OP_MIX_P_ACC;
                state_next = ST_DRAIN;
            end
            ST_DRAIN: begin
                // last product is rounded into the pitch angle here
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.commit) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

// ===== rtl/icaf_dpath.sv =====
// Datapath of the IMU angle filter: sample registers, one shared 17x17
// multiplier with rounding, angle state and the result register. Uses icaf_pkg.
module icaf_dpath (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  icaf_pkg::cmd_t                       cmd,
    input  logic [icaf_pkg::S_TDATA_W-1:0]       s_data,
    input  logic [icaf_pkg::TRIM_W-1:0]          trim_roll,
    input  logic [icaf_pkg::TRIM_W-1:0]          trim_pitch,
    input  logic [icaf_pkg::WEIGHT_W-1:0]        mix_weight,
    output logic [icaf_pkg::M_TDATA_W-1:0]       m_data
);
    import icaf_pkg::*;

    logic [SAMPLE_W-1:0] acc_roll_in, acc_pitch_in, acc_vert_in;
    logic [SAMPLE_W-1:0] gyro_roll_in, gyro_pitch_in, gyro_yaw_in;
    logic [TICK_W-1:0]   now_in;
    logic [DT_W-1:0]     dt_in;

    logic [SAMPLE_W-1:0] g_r_reg, g_p_reg, g_y_reg;
    logic [ANGLE_W-1:0]  acc_r_reg, acc_p_reg, acc_v_reg;
    logic [DT_W-1:0]     dt_reg;
    logic [TICK_W-1:0]   last_ticks_reg;
    logic [ANGLE_W-1:0]  angle_r_reg, angle_p_reg, angle_y_reg;
    logic [SAMPLE_W-1:0] rate_r_reg, rate_p_reg, rate_y_reg;
    logic [PROD_W-1:0]   prod_reg, sum_reg;
    op_t                 op_d_reg;
    logic [M_TDATA_W-1:0] m_data_reg;

    logic [WEIGHT_W-1:0]    weight_eff, weight_inv;
    logic [ANGLE_W-1:0]     s_r, s_p, yaw_new;
    logic signed [MUL_W-1:0]     mul_a, mul_b;
    logic signed [2*MUL_W-1:0]   product;
    logic [SAMPLE_W-1:0]    rate_rnd;
    logic [PROD_W-1:0]      mix_total;
    logic [ANGLE_W-1:0]     mix_rnd;

    assign acc_roll_in   = s_data[10:0];
    assign acc_pitch_in  = s_data[21:11];
    assign acc_vert_in   = s_data[32:22];
    assign gyro_roll_in  = s_data[43:33];
    assign gyro_pitch_in = s_data[54:44];
    assign gyro_yaw_in   = s_data[65:55];
    assign now_in        = s_data[97:66];
    assign dt_in         = now_in[DT_W-1:0] - last_ticks_reg[DT_W-1:0];

    assign weight_eff = (mix_weight > WEIGHT_FULL) ? WEIGHT_FULL : mix_weight;
    assign weight_inv = WEIGHT_FULL - weight_eff;

    assign s_r     = angle_r_reg + {{(ANGLE_W-SAMPLE_W){rate_r_reg[SAMPLE_W-1]}}, rate_r_reg};
    assign s_p     = angle_p_reg + {{(ANGLE_W-SAMPLE_W){rate_p_reg[SAMPLE_W-1]}}, rate_p_reg};
    assign yaw_new = angle_y_reg + {{(ANGLE_W-SAMPLE_W){rate_y_reg[SAMPLE_W-1]}}, rate_y_reg};

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.op)
            OP_RATE_R: begin
                mul_a = {{(MUL_W-SAMPLE_W){g_r_reg[SAMPLE_W-1]}}, g_r_reg};
                mul_b = {1'b0, dt_reg};
            end
            OP_RATE_P: begin
                mul_a = {{(MUL_W-SAMPLE_W){g_p_reg[SAMPLE_W-1]}}, g_p_reg};
                mul_b = {1'b0, dt_reg};
            end
            OP_RATE_Y: begin
                mul_a = {{(MUL_W-SAMPLE_W){g_y_reg[SAMPLE_W-1]}}, g_y_reg};
                mul_b = {1'b0, dt_reg};
            end
            OP_MIX_R_GYRO: begin
                mul_a = {s_r[ANGLE_W-1], s_r};
                mul_b = {{(MUL_W-WEIGHT_W){1'b0}}, weight_inv};
            end
            OP_MIX_R_ACC: begin
                mul_a = {acc_r_reg[ANGLE_W-1], acc_r_reg};
                mul_b = {{(MUL_W-WEIGHT_W){1'b0}}, weight_eff};
            end
            OP_MIX_P_GYRO: begin
                mul_a = {s_p[ANGLE_W-1], s_p};
                mul_b = {{(MUL_W-WEIGHT_W){1'b0}}, weight_inv};
            end
            OP_MIX_P_ACC: begin
                mul_a = {acc_p_reg[ANGLE_W-1], acc_p_reg};
                mul_b = {{(MUL_W-WEIGHT_W){1'b0}}, weight_eff};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign product = mul_a * mul_b;

    // floor shift, then one added back on negative results (round to zero-ish)
    assign rate_rnd  = prod_reg[PROD_W-1:DT_W] + {{(SAMPLE_W-1){1'b0}}, prod_reg[PROD_W-1]};
    assign mix_total = sum_reg + prod_reg;
    assign mix_rnd   = mix_total[23:8] + {{(ANGLE_W-1){1'b0}}, mix_total[PROD_W-1]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_d_reg       <= OP_NONE;
            last_ticks_reg <= '0;
            angle_r_reg    <= '0;
            angle_p_reg    <= '0;
            angle_y_reg    <= '0;
        end else begin
            op_d_reg <= cmd.op;
            if (cmd.load) begin
                // only the 16-bit delta is consumed
                last_ticks_reg <= last_ticks_reg + {{(TICK_W-DT_W){1'b0}}, dt_in};
            end
            case (op_d_reg)
                OP_MIX_R_ACC: angle_r_reg <= mix_rnd;
                OP_MIX_P_ACC: angle_p_reg <= mix_rnd;
                default: ;
            endcase
            if (cmd.commit) begin
                angle_y_reg <= yaw_new;
            end
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= product[PROD_W-1:0];
        if (cmd.load) begin
            g_r_reg   <= gyro_roll_in;
            g_p_reg   <= gyro_pitch_in;
            g_y_reg   <= gyro_yaw_in;
            dt_reg    <= dt_in;
            acc_r_reg <= tilt_from_accel(acc_roll_in, {trim_roll, 8'd0});
            acc_p_reg <= tilt_from_accel(acc_pitch_in, {trim_pitch, 8'd0});
            acc_v_reg <= tilt_from_accel(acc_vert_in, VERT_OFFSET);
        end
        case (op_d_reg)
            OP_RATE_R:     rate_r_reg <= rate_rnd;
            OP_RATE_P:     rate_p_reg <= rate_rnd;
            OP_RATE_Y:     rate_y_reg <= rate_rnd;
            OP_MIX_R_GYRO: sum_reg    <= prod_reg;
            OP_MIX_P_GYRO: sum_reg    <= prod_reg;
            default: ;
        endcase
        if (cmd.commit) begin
            m_data_reg <= {7'd0, rate_y_reg, rate_p_reg, rate_r_reg,
                           acc_v_reg, acc_p_reg, acc_r_reg,
                           yaw_new, angle_p_reg, angle_r_reg};
        end
    end

    assign m_data = m_data_reg;

endmodule

// ===== rtl/imu_complementary_angle_filter_top.sv =====
// Top level of the IMU complementary angle filter: configuration registers,
// sequencer and datapath. Depends on icaf_pkg, icaf_ctrl and icaf_dpath.
//
// Usage:
//   One request on the s_ channel carries a full IMU sample (three
//   accelerometer axes, three gyro axes, timer ticks). Each request yields
//   exactly one result on the m_ channel with the filtered roll, pitch and
//   yaw angles, the accelerometer angles and the per-step gyro increments.
//   Configuration (trims, mix weight) is written through cfg_wr_en,
//   cfg_addr and cfg_wdata while the block is idle.
//
//   Sequence: a sample is taken while idle, then the single shared 17x17
//   multiplier runs seven products (three gyro rates, two per mixed axis)
//   plus a rounding step; the result is then registered into the output
//   register once it is free.
//   s_tready is high only while no sample is in work. A finished result
//   sits in the output register while the next sample is accepted; if the
//   receiver stalls, the following result waits in the sequencer until
//   the output register frees up.
//   Reset clears the angle and tick state and loads default trims (zero)
//   and a raw mix weight of one, i.e. 1/256 of the full weight of 256.
module imu_complementary_angle_filter_top (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // acc_roll, acc_pitch, acc_vertical, gyro_roll, gyro_pitch, gyro_yaw,
    // now_ticks, zero fill
    input  logic [icaf_pkg::S_TDATA_W-1:0]        s_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // angle_roll, angle_pitch, angle_yaw, acc_angle_roll, acc_angle_pitch,
    // acc_angle_vertical, rate_roll, rate_pitch, rate_yaw, zero fill
    output logic [icaf_pkg::M_TDATA_W-1:0]        m_tdata,
    input  logic                                  cfg_wr_en,
    input  logic [icaf_pkg::CFG_IDX_W-1:0]        cfg_addr,
    input  logic [icaf_pkg::WEIGHT_W-1:0]         cfg_wdata
);
    import icaf_pkg::*;

    logic [TRIM_W-1:0]   trim_roll_reg, trim_pitch_reg;
    logic [WEIGHT_W-1:0] mix_weight_reg;
    cmd_t                ctrl_cmd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trim_roll_reg  <= '0;
            trim_pitch_reg <= '0;
            mix_weight_reg <= WEIGHT_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_TRIM_ROLL:  trim_roll_reg  <= cfg_wdata[TRIM_W-1:0];
                CFG_TRIM_PITCH: trim_pitch_reg <= cfg_wdata[TRIM_W-1:0];
                CFG_MIX_WEIGHT: mix_weight_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    icaf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .cmd      (ctrl_cmd)
    );

    icaf_dpath u_dpath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (ctrl_cmd),
        .s_data     (s_tdata),
        .trim_roll  (trim_roll_reg),
        .trim_pitch (trim_pitch_reg),
        .mix_weight (mix_weight_reg),
        .m_data     (m_tdata)
    );

    // one sample in work at a time
    a_single_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request accepted while a sample is in work");

    // a result is only written into a free output register
    a_commit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl_cmd.commit |-> (!m_tvalid || m_tready))
        else $error("result committed over an unread result");

    a_commit_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl_cmd.commit |=> m_tvalid)
        else $error("committed result not presented");

    // sampling and committing never coincide
    a_load_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ctrl_cmd.load && ctrl_cmd.commit))
        else $error("load and commit in the same cycle");

endmodule
